@@ sv/ithp_pkg.sv @@
// Shared widths, constants and register codes of the iteration-to-HSV palette.
`default_nettype none
package ithp_pkg;

    // Field widths fixed by the interface.
    localparam int CNT_W = 16;
    localparam int OFF_W = 8;
    localparam int CH_W  = 8;

    // Hue numerator and denominator widths: k needs 17 bits, 6*(19+400k) needs 28,
    // and 19+400*(limit+offset) stays below 2^25.
    localparam int K_W   = 17;
    localparam int NUM_W = 28;
    localparam int DEN_W = 25;

    // Integer part of six times the hue (0..6).
    localparam int SECT_W = 3;

    // Default number of fractional quotient bits.
    localparam int FRAC_BITS_DEF = 16;

    // Hue ramp constants.
    localparam int HUE_BASE = 19;
    localparam int HUE_STEP = 400;
    localparam int HUE_SIX  = 6;

    // Channel levels scaled by 255 at saturation 0.8.
    localparam logic [CH_W-1:0] LEVEL_V = 8'd255;
    localparam logic [CH_W-1:0] LEVEL_P = 8'd51;
    localparam logic [CH_W-1:0] SLOPE   = 8'd204;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;
    localparam logic [CNT_W-1:0] LIMIT_RESET  = 16'd50;
    localparam logic [OFF_W-1:0] OFFSET_RESET = 8'd0;

endpackage
`default_nettype wire

@@ sv/ithp_prep.sv @@
// Front stage: saturates the count and forms the hue numerator and denominator.
`default_nettype none
module ithp_prep #(
    parameter int FRAC_BITS = ithp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ithp_pkg::CNT_W-1:0]  escape_count,
    input  wire logic [ithp_pkg::CNT_W-1:0]  limit,
    input  wire logic [ithp_pkg::OFF_W-1:0]  offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ithp_pkg::DEN_W-1:0]       out_rem,
    output logic [FRAC_BITS+2:0]             out_qd,
    output logic [ithp_pkg::DEN_W-1:0]       out_den
);
    localparam int Q_W = FRAC_BITS + 3;

    logic                        valid_reg;
    logic [ithp_pkg::DEN_W-1:0]  rem_reg;
    logic [Q_W-1:0]              qd_reg;
    logic [ithp_pkg::DEN_W-1:0]  den_reg;

    logic [ithp_pkg::CNT_W-1:0]  count_sat;
    logic [ithp_pkg::K_W-1:0]    k_val;
    logic [ithp_pkg::K_W-1:0]    span;
    logic [ithp_pkg::NUM_W-1:0]  base;
    logic [ithp_pkg::NUM_W-1:0]  num;
    logic [ithp_pkg::NUM_W-1:0]  den_full;

    // Hue numerator 6*(19+400k) and denominator 19+400*(limit+offset).
    always_comb
    begin
        count_sat = (escape_count > limit) ? limit : escape_count;
        k_val     = ithp_pkg::K_W'(offset) + ithp_pkg::K_W'(limit)
                  - ithp_pkg::K_W'(count_sat);
        span      = ithp_pkg::K_W'(limit) + ithp_pkg::K_W'(offset);
        base      = ithp_pkg::NUM_W'(ithp_pkg::HUE_BASE)
                  + ithp_pkg::NUM_W'(k_val) * ithp_pkg::NUM_W'(ithp_pkg::HUE_STEP);
        num       = base * ithp_pkg::NUM_W'(ithp_pkg::HUE_SIX);
        den_full  = ithp_pkg::NUM_W'(ithp_pkg::HUE_BASE)
                  + ithp_pkg::NUM_W'(span) * ithp_pkg::NUM_W'(ithp_pkg::HUE_STEP);
    end

    assign in_ready = !valid_reg || out_ready;

    // The dividend is num * 2^FRAC_BITS; its bits above the quotient width seed the
    // remainder, and the low three numerator bits lead the bits still to shift in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg <= num[ithp_pkg::NUM_W-1:3];
            qd_reg  <= {num[2:0], FRAC_BITS'(0)};
            den_reg <= den_full[ithp_pkg::DEN_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_qd    = qd_reg;
    assign out_den   = den_reg;

endmodule
`default_nettype wire

@@ sv/ithp_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and passes the item on.
`default_nettype none
module ithp_div_cell #(
    parameter int Q_W = ithp_pkg::FRAC_BITS_DEF + 3
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ithp_pkg::DEN_W-1:0]  in_rem,
    input  wire logic [Q_W-1:0]              in_qd,
    input  wire logic [ithp_pkg::DEN_W-1:0]  in_den,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ithp_pkg::DEN_W-1:0]       out_rem,
    output logic [Q_W-1:0]                   out_qd,
    output logic [ithp_pkg::DEN_W-1:0]       out_den
);
    localparam int DEN_W = ithp_pkg::DEN_W;

    logic               valid_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [Q_W-1:0]     qd_reg;
    logic [DEN_W-1:0]   den_reg;

    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     diff;
    logic               ge;
    logic [DEN_W-1:0]   rem_next;
    logic [Q_W-1:0]     qd_next;

    // Shift the next dividend bit into the remainder and try to subtract.
    always_comb
    begin
        shifted  = {in_rem, in_qd[Q_W-1]};
        diff     = shifted - {1'b0, in_den};
        ge       = (shifted >= {1'b0, in_den});
        rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        qd_next  = {in_qd[Q_W-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg <= rem_next;
            qd_reg  <= qd_next;
            den_reg <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_qd    = qd_reg;
    assign out_den   = den_reg;

endmodule
`default_nettype wire

@@ sv/ithp_color.sv @@
// Back stage: turns six times the hue into RGB levels and holds the result.
`default_nettype none
module ithp_color #(
    parameter int FRAC_BITS = ithp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [FRAC_BITS+2:0]       hue6,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [ithp_pkg::CH_W-1:0]       red,
    output logic [ithp_pkg::CH_W-1:0]       green,
    output logic [ithp_pkg::CH_W-1:0]       blue
);
    localparam int CH_W   = ithp_pkg::CH_W;
    localparam int PROD_W = FRAC_BITS + CH_W;

    localparam logic [ithp_pkg::SECT_W-1:0] SECT_RED_UP   = 3'd0;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_GREEN_IN = 3'd1;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_BLUE_UP  = 3'd2;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_GREEN_DN = 3'd3;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_RED_IN   = 3'd4;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_BLUE_DN  = 3'd5;
    localparam logic [ithp_pkg::SECT_W-1:0] SECT_FULL     = 3'd6;

    logic               valid_reg;
    logic [CH_W-1:0]    red_reg;
    logic [CH_W-1:0]    green_reg;
    logic [CH_W-1:0]    blue_reg;

    logic [ithp_pkg::SECT_W-1:0] sector;
    logic [PROD_W-1:0]  prod;
    logic [CH_W-1:0]    ramp;
    logic               ramp_frac;
    logic [CH_W-1:0]    lvl_q;
    logic [CH_W-1:0]    lvl_t;
    logic [CH_W-1:0]    red_next;
    logic [CH_W-1:0]    green_next;
    logic [CH_W-1:0]    blue_next;

    // Falling level q truncates 255*(1-0.8f), so the scaled fraction rounds up;
    // rising level t rounds it down.
    always_comb
    begin
        sector    = hue6[FRAC_BITS+2:FRAC_BITS];
        prod      = PROD_W'(ithp_pkg::SLOPE) * PROD_W'(hue6[FRAC_BITS-1:0]);
        ramp      = prod[PROD_W-1:FRAC_BITS];
        ramp_frac = (prod[FRAC_BITS-1:0] != '0);
        lvl_q     = ithp_pkg::LEVEL_V - ramp - CH_W'(ramp_frac);
        lvl_t     = ithp_pkg::LEVEL_P + ramp;
    end

    // Sector arrangement; a hue of exactly one shares the last sector's colors.
    always_comb
    begin
        case (sector) inside
            SECT_RED_UP:
            begin
                red_next = ithp_pkg::LEVEL_V; green_next = lvl_t; blue_next = ithp_pkg::LEVEL_P;
            end
            SECT_GREEN_IN:
            begin
                red_next = lvl_q; green_next = ithp_pkg::LEVEL_V; blue_next = ithp_pkg::LEVEL_P;
            end
            SECT_BLUE_UP:
            begin
                red_next = ithp_pkg::LEVEL_P; green_next = ithp_pkg::LEVEL_V; blue_next = lvl_t;
            end
            SECT_GREEN_DN:
            begin
                red_next = ithp_pkg::LEVEL_P; green_next = lvl_q; blue_next = ithp_pkg::LEVEL_V;
            end
            SECT_RED_IN:
            begin
                red_next = lvl_t; green_next = ithp_pkg::LEVEL_P; blue_next = ithp_pkg::LEVEL_V;
            end
            SECT_BLUE_DN, SECT_FULL:
            begin
                red_next = ithp_pkg::LEVEL_V; green_next = ithp_pkg::LEVEL_P; blue_next = lvl_q;
            end
            default:
            begin
                red_next = ithp_pkg::LEVEL_V; green_next = ithp_pkg::LEVEL_P; blue_next = lvl_q;
            end
        endcase
    end

    assign in_ready = !valid_reg || !out_stall;

    // Output register: a new color loads whenever the held one is taken or absent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule
`default_nettype wire

@@ sv/iteration_to_hsv_palette.sv @@
// Top level of the escape-count to RGB palette with its configuration registers.
`default_nettype none
// Maps each escape-iteration count to an RGB color on an HSV wheel with saturation
// 0.8 and value 1. The block accepts one count per clock while in_stall is low and
// returns one color per count, in order. A front stage forms the hue numerator and
// denominator, a chain of FRAC_BITS + 3 division cells resolves one quotient bit
// each, and a back stage picks the sector levels into the output register. Any
// stage that holds a bubble still takes new data while the output is stalled.
// Registers (APB, byte address 4*i): 0 iteration_limit (16 bits, reset 50),
// 1 palette_offset (8 bits, reset 0); write them only while the block is empty.
module iteration_to_hsv_palette #(
    parameter int FRAC_BITS = ithp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ithp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ithp_pkg::DATA_W-1:0]   pwdata,
    output logic [ithp_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ithp_pkg::CNT_W-1:0]    escape_count,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ithp_pkg::CH_W-1:0]          red,
    output logic [ithp_pkg::CH_W-1:0]          green,
    output logic [ithp_pkg::CH_W-1:0]          blue
);
    localparam int Q_W   = FRAC_BITS + 3;
    localparam int DEN_W = ithp_pkg::DEN_W;

    logic [ithp_pkg::CNT_W-1:0] limit_reg;
    logic [ithp_pkg::OFF_W-1:0] offset_reg;
    logic                       cfg_write;

    logic                       stg_valid [0:Q_W];
    logic                       stg_ready [0:Q_W];
    logic [DEN_W-1:0]           stg_rem   [0:Q_W];
    logic [Q_W-1:0]             stg_qd    [0:Q_W];
    logic [DEN_W-1:0]           stg_den   [0:Q_W];
    logic                       prep_ready;

    // Configuration registers; every transfer completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= ithp_pkg::LIMIT_RESET;
            offset_reg <= ithp_pkg::OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                ithp_pkg::REG_LIMIT:  limit_reg  <= pwdata[ithp_pkg::CNT_W-1:0];
                ithp_pkg::REG_OFFSET: offset_reg <= pwdata[ithp_pkg::OFF_W-1:0];
                default:              limit_reg  <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ithp_pkg::REG_LIMIT:  prdata = ithp_pkg::DATA_W'(limit_reg);
            ithp_pkg::REG_OFFSET: prdata = ithp_pkg::DATA_W'(offset_reg);
            default:              prdata = '0;
        endcase
    end

    // Hue numerator and denominator.
    assign in_stall = !prep_ready;

    ithp_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (prep_ready),
        .escape_count (escape_count),
        .limit        (limit_reg),
        .offset       (offset_reg),
        .out_valid    (stg_valid[0]),
        .out_ready    (stg_ready[0]),
        .out_rem      (stg_rem[0]),
        .out_qd       (stg_qd[0]),
        .out_den      (stg_den[0])
    );

    // Chain of division cells, one quotient bit per cell.
    for (genvar gi = 0; gi < Q_W; gi++)
    begin : g_div
        ithp_div_cell #(
            .Q_W (Q_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[gi]),
            .in_ready  (stg_ready[gi]),
            .in_rem    (stg_rem[gi]),
            .in_qd     (stg_qd[gi]),
            .in_den    (stg_den[gi]),
            .out_valid (stg_valid[gi+1]),
            .out_ready (stg_ready[gi+1]),
            .out_rem   (stg_rem[gi+1]),
            .out_qd    (stg_qd[gi+1]),
            .out_den   (stg_den[gi+1])
        );
    end

    // Sector levels and output register.
    ithp_color #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[Q_W]),
        .in_ready  (stg_ready[Q_W]),
        .hue6      (stg_qd[Q_W]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

`ifndef NO_ASSERTIONS
    // The final quotient never exceeds six whole sectors.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[Q_W] |-> (stg_qd[Q_W][Q_W-1:FRAC_BITS] <= 3'd6))
        else $error("hue quotient beyond sector six");

    // The remainder leaving the last cell stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[Q_W] |-> (stg_rem[Q_W] < stg_den[Q_W]))
        else $error("division remainder not below divisor");

    // A color appears at the output only after the last cell held an item.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stg_valid[Q_W]))
        else $error("output valid without a finished division");

    // The front stage seeds a remainder below the divisor.
    a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[0] |-> (stg_rem[0] < stg_den[0]))
        else $error("seed remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ sim/iteration_to_hsv_palette_tb.sv @@
// Self-checking testbench for the escape-count to RGB palette block.
`timescale 1ns / 100ps

module iteration_to_hsv_palette_tb;

    localparam int FRAC     = ithp_pkg::FRAC_BITS_DEF;
    localparam int LATENCY  = FRAC + 5;
    localparam int IDLE_PCT = 26;
    localparam int PHASES   = 9;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int CALM_PHASE = 3;
    localparam longint CYCLE_LIMIT = 200000;

    // Hue sectors of the color wheel; sector 6 folds onto the last one.
    typedef enum logic [ithp_pkg::SECT_W-1:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5,
        SECT_FULL_TURN     = 3'd6
    } hue_sector_t;

    typedef struct packed {
        logic [ithp_pkg::CH_W-1:0] red;
        logic [ithp_pkg::CH_W-1:0] green;
        logic [ithp_pkg::CH_W-1:0] blue;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ithp_pkg::ADDR_W-1:0] paddr = '0;
    logic [ithp_pkg::DATA_W-1:0] pwdata = '0;
    logic [ithp_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ithp_pkg::CNT_W-1:0] escape_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ithp_pkg::CH_W-1:0] red;
    logic [ithp_pkg::CH_W-1:0] green;
    logic [ithp_pkg::CH_W-1:0] blue;

    // Testbench copy of the configuration registers.
    logic [ithp_pkg::CNT_W-1:0] cfg_limit = ithp_pkg::LIMIT_RESET;
    logic [ithp_pkg::OFF_W-1:0] cfg_offset = ithp_pkg::OFFSET_RESET;

    logic [ithp_pkg::CNT_W-1:0] pending_counts[$];
    rgb_t expected_colors[$];
    int error_count = 0;
    bit calm = 1'b0;
    longint cycle_count = 0;

    iteration_to_hsv_palette #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .escape_count(escape_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .red(red), .green(green), .blue(blue)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Color of one count: hue ramp, exact division, then the sector levels.
    function automatic rgb_t palette_color(logic [ithp_pkg::CNT_W-1:0] count,
                                           logic [ithp_pkg::CNT_W-1:0] lim,
                                           logic [ithp_pkg::OFF_W-1:0] off);
        longint unsigned c, k, num, den, h6, f, prod, mask, frac_dn, frac_up;
        logic [ithp_pkg::CH_W-1:0] lv, lp, lq, lt;
        hue_sector_t sector;
        rgb_t color;
        mask = (64'd1 << FRAC) - 1;
        c = (count > lim) ? longint'(lim) : longint'(count);
        k = longint'(off) + longint'(lim) - c;
        num = ithp_pkg::HUE_SIX * (ithp_pkg::HUE_BASE + ithp_pkg::HUE_STEP * k);
        den = ithp_pkg::HUE_BASE
            + ithp_pkg::HUE_STEP * (longint'(lim) + longint'(off));
        h6 = (num << FRAC) / den;
        sector = hue_sector_t'(h6 >> FRAC);
        f = h6 & mask;
        prod = longint'(ithp_pkg::SLOPE) * f;
        frac_dn = prod >> FRAC;
        frac_up = frac_dn + (((prod & mask) != 0) ? 1 : 0);
        lv = ithp_pkg::LEVEL_V;
        lp = ithp_pkg::LEVEL_P;
        lq = ithp_pkg::LEVEL_V - ithp_pkg::CH_W'(frac_up);
        lt = ithp_pkg::LEVEL_P + ithp_pkg::CH_W'(frac_dn);
        case (sector)
            SECT_RED_YELLOW:   color = '{lv, lt, lp};
            SECT_YELLOW_GREEN: color = '{lq, lv, lp};
            SECT_GREEN_CYAN:   color = '{lp, lv, lt};
            SECT_CYAN_BLUE:    color = '{lp, lq, lv};
            SECT_BLUE_MAGENTA: color = '{lt, lp, lv};
            default:           color = '{lv, lp, lq};
        endcase
        return color;
    endfunction

    // Register write: setup cycle, access cycle, done when pready is high.
    task automatic reg_write(logic reg_code, logic [ithp_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_code, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_code == ithp_pkg::REG_LIMIT)
            cfg_limit = value[ithp_pkg::CNT_W-1:0];
        else
            cfg_offset = value[ithp_pkg::OFF_W-1:0];
    endtask

    // Random count: mostly inside the limit, with the edges and saturation mixed in.
    function automatic logic [ithp_pkg::CNT_W-1:0] random_count(
        logic [ithp_pkg::CNT_W-1:0] lim);
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return lim;
        else if (pick < 30 && lim != '1)
            return ithp_pkg::CNT_W'($urandom_range(int'(lim) + 1, 65535));
        else if (pick < 40)
            return ithp_pkg::CNT_W'($urandom);
        else
            return ithp_pkg::CNT_W'($urandom_range(0, int'(lim)));
    endfunction

    // Input driver: presents queued counts and records the expected color per transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            escape_count <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_colors.push_back(palette_color(escape_count, cfg_limit, cfg_offset));
            if (!in_valid || !in_stall)
            begin
                if (pending_counts.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    escape_count <= pending_counts.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each transfer against the oldest expected color.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("unexpected color transfer: red %0d green %0d blue %0d",
                           red, green, blue);
                    error_count++;
                end
                else
                begin
                    rgb_t exp_color;
                    exp_color = expected_colors.pop_front();
                    if (red !== exp_color.red)
                    begin
                        $error("red: expected %0d, actual %0d", exp_color.red, red);
                        error_count++;
                    end
                    if (green !== exp_color.green)
                    begin
                        $error("green: expected %0d, actual %0d", exp_color.green, green);
                        error_count++;
                    end
                    if (blue !== exp_color.blue)
                    begin
                        $error("blue: expected %0d, actual %0d", exp_color.blue, blue);
                        error_count++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: one phase per register setting, draining the block between phases.
    initial
    begin
        logic [ithp_pkg::CNT_W-1:0] lim;
        logic [ithp_pkg::OFF_W-1:0] off;
        logic [ithp_pkg::CNT_W-1:0] directed[$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin lim = ithp_pkg::LIMIT_RESET; off = ithp_pkg::OFFSET_RESET; end
                1: begin lim = 16'd1;     off = 8'd0;   end
                2: begin lim = 16'hFFFF;  off = 8'hFF;  end
                3: begin lim = 16'd1;     off = 8'hFF;  end
                4: begin lim = 16'hFFFF;  off = 8'd0;   end
                default:
                begin
                    lim = ($urandom_range(1) != 0)
                        ? ithp_pkg::CNT_W'($urandom_range(1, 300))
                        : ithp_pkg::CNT_W'($urandom_range(1, 65535));
                    off = ithp_pkg::OFF_W'($urandom_range(0, 255));
                end
            endcase
            // The reset setting is used as it is; later phases write both registers,
            // with junk in the unused upper data bits.
            if (phase != 0)
            begin
                reg_write(ithp_pkg::REG_LIMIT,
                          ($urandom & 32'hFFFF_0000) | ithp_pkg::DATA_W'(lim));
                reg_write(ithp_pkg::REG_OFFSET,
                          ($urandom & 32'hFFFF_FF00) | ithp_pkg::DATA_W'(off));
            end
            calm = (phase == CALM_PHASE);

            // Directed counts: both ends, the limit, saturation and bit patterns.
            if (phase == 0)
            begin
                directed = '{16'd0, 16'd1, 16'd8, 16'd17, 16'd25, 16'd33, 16'd42,
                             16'd49, 16'd50, 16'd51, 16'h5555, 16'hAAAA, 16'hFFFF};
                foreach (directed[i])
                    pending_counts.push_back(directed[i]);
            end
            else if (phase <= 4)
            begin
                pending_counts.push_back(16'd0);
                pending_counts.push_back(lim);
                pending_counts.push_back(16'hFFFF);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pending_counts.push_back(random_count(lim));

            // Drain: every item accepted and every color back, then settle.
            while (pending_counts.size() != 0 || in_valid || expected_colors.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 10) @(posedge clk);
        end

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ iteration_to_hsv_palette.f @@
sv/ithp_pkg.sv
sv/ithp_prep.sv
sv/ithp_div_cell.sv
sv/ithp_color.sv
sv/iteration_to_hsv_palette.sv
sim/iteration_to_hsv_palette_tb.sv
